// ----- hdl/tctg_pkg.sv -----
// Package for the tilt controlled tone generator.
// Holds shared widths, register indexes, CORDIC constants and the arctangent table.
// Depends on nothing.
package tctg_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int MARKER_W = 8;
    localparam int STEP_W = 32;
    localparam int AMP_W = 15;
    localparam int SAMPLE_W = 16;

    localparam int XY_W = 33;
    localparam int Z_W = 34;
    localparam int ANGLE_W = 32;
    localparam int ITER_W = 5;
    localparam int NORM_W = 17;
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 17;
    localparam int PROD_W = MUL_A_W + MUL_B_W;

    localparam int SINE_STAGES = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_MARKER = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_STEP = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPAN_STEP = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE = 2'd3;

    localparam logic [MARKER_W-1:0] FRAME_MARKER_RESET = 8'hAA;
    localparam logic [STEP_W-1:0] BASE_STEP_RESET = 32'd21426141;
    localparam logic [STEP_W-1:0] SPAN_STEP_RESET = 32'd64278422;
    localparam logic [AMP_W-1:0] AMPLITUDE_RESET = 15'd9830;

    localparam logic signed [XY_W-1:0] SINE_START = 33'sd652032874;
    localparam logic signed [Z_W-1:0] HALF_TURN = 34'sd2147483648;
    localparam logic signed [Z_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [Z_W-1:0] FULL_TURN = 34'sd4294967296;

    localparam logic [NORM_W-1:0] NORM_POS_AXIS = 17'd32768;
    localparam logic [NORM_W-1:0] NORM_NEG_AXIS = 17'd65536;

    typedef struct packed {
        logic              load;
        logic              iterate;
        logic              vectoring;
        logic [ITER_W-1:0] idx;
    } cordic_ctrl_t;

    function automatic logic [ANGLE_W-1:0] turn_atan(input logic [ITER_W-1:0] i);
        logic [ANGLE_W-1:0] r;
        unique case (i)
            5'd0:    r = 32'd536870912;
            5'd1:    r = 32'd316933406;
            5'd2:    r = 32'd167458907;
            5'd3:    r = 32'd85004756;
            5'd4:    r = 32'd42667331;
            5'd5:    r = 32'd21354465;
            5'd6:    r = 32'd10680862;
            5'd7:    r = 32'd5340245;
            5'd8:    r = 32'd2670163;
            5'd9:    r = 32'd1335087;
            5'd10:   r = 32'd667544;
            5'd11:   r = 32'd333772;
            5'd12:   r = 32'd166886;
            5'd13:   r = 32'd83443;
            5'd14:   r = 32'd41722;
            5'd15:   r = 32'd20861;
            5'd16:   r = 32'd10430;
            5'd17:   r = 32'd5215;
            5'd18:   r = 32'd2608;
            5'd19:   r = 32'd1304;
            5'd20:   r = 32'd652;
            5'd21:   r = 32'd326;
            5'd22:   r = 32'd163;
            5'd23:   r = 32'd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/tctg_frame.sv -----
// Serial frame receiver: hunts for the marker byte and collects the x and y words.
// Depends on tctg_pkg.
module tctg_frame (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          byte_en,
    input  logic [7:0]                    rx_byte,
    input  logic [tctg_pkg::MARKER_W-1:0] marker,
    output logic                          frame_done,
    output logic [15:0]                   x_word,
    output logic [15:0]                   y_word
);

    localparam logic [2:0] POS_HUNT = 3'd0;
    localparam logic [2:0] POS_X_LO = 3'd1;
    localparam logic [2:0] POS_X_HI = 3'd2;
    localparam logic [2:0] POS_Y_LO = 3'd3;
    localparam logic [2:0] POS_Y_HI = 3'd4;
    localparam logic [2:0] POS_LAST = 3'd6;

    logic [2:0]  pos_reg, pos_next;
    logic [15:0] x_reg, x_next;
    logic [15:0] y_reg, y_next;

    always_comb
    begin
        pos_next = pos_reg;
        x_next = x_reg;
        y_next = y_reg;
        frame_done = 1'b0;
        if (byte_en)
        begin
            if (pos_reg == POS_HUNT)
            begin
                if (rx_byte == marker)
                begin
                    pos_next = POS_X_LO;
                end
            end
            else
            begin
                if (pos_reg == POS_X_LO)
                begin
                    x_next[7:0] = rx_byte;
                end
                if (pos_reg == POS_X_HI)
                begin
                    x_next[15:8] = rx_byte;
                end
                if (pos_reg == POS_Y_LO)
                begin
                    y_next[7:0] = rx_byte;
                end
                if (pos_reg == POS_Y_HI)
                begin
                    y_next[15:8] = rx_byte;
                end
                if (pos_reg >= POS_LAST)
                begin
                    pos_next = POS_HUNT;
                    frame_done = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HUNT;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign x_word = x_reg;
    assign y_word = y_reg;

endmodule

// ----- hdl/tctg_cordic.sv -----
// Shared CORDIC stage: one shift, add and subtract unit applied once per cycle while iterate is set.
// Serves both vectoring (arctangent) and rotation (sine). Depends on tctg_pkg.
module tctg_cordic (
    input  logic                                 clk,
    input  tctg_pkg::cordic_ctrl_t               ctrl,
    input  logic signed [tctg_pkg::XY_W-1:0]     load_x,
    input  logic signed [tctg_pkg::XY_W-1:0]     load_y,
    input  logic signed [tctg_pkg::Z_W-1:0]      load_z,
    output logic signed [tctg_pkg::XY_W-1:0]     y_out,
    output logic signed [tctg_pkg::Z_W-1:0]      z_out
);

    logic signed [tctg_pkg::XY_W-1:0] x_reg, x_next;
    logic signed [tctg_pkg::XY_W-1:0] y_reg, y_next;
    logic signed [tctg_pkg::Z_W-1:0]  z_reg, z_next;
    logic signed [tctg_pkg::XY_W-1:0] x_shift;
    logic signed [tctg_pkg::XY_W-1:0] y_shift;
    logic signed [tctg_pkg::Z_W-1:0]  atan_z;
    logic                             cw;

    assign x_shift = x_reg >>> ctrl.idx;
    assign y_shift = y_reg >>> ctrl.idx;
    assign atan_z = signed'({2'b00, tctg_pkg::turn_atan(ctrl.idx)});
    assign cw = ctrl.vectoring ? (y_reg > 0) : z_reg[tctg_pkg::Z_W-1];

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        priority if (ctrl.load)
        begin
            x_next = load_x;
            y_next = load_y;
            z_next = load_z;
        end
        else if (ctrl.iterate)
        begin
            if (cw)
            begin
                x_next = x_reg + y_shift;
                y_next = y_reg - x_shift;
                z_next = z_reg + atan_z;
            end
            else
            begin
                x_next = x_reg - y_shift;
                y_next = y_reg + x_shift;
                z_next = z_reg - atan_z;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// ----- hdl/tilt_controlled_tone_generator.sv -----
// Tilt controlled tone generator: atan2 steered phase accumulator with a CORDIC sine.
// A plain byte is taken while idle; a frame-ending byte keeps the block busy through
// the CORDIC vectoring passes, normalise, multiply and step states (only multiply and
// step when y is zero). A tick runs 24 CORDIC passes, then operand, multiply and output
// steps into the output register; the multiplier is shared by both paths.
// Reset is asynchronous; control and config registers reset at once, no clearing pass.
module tilt_controlled_tone_generator #(
    parameter int PHASE_BITS = 32,
    parameter int ANGLE_ITERATIONS = 16,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic                                 func,
    input  logic [7:0]                           serial_byte,
    output logic                                 sample_valid,
    input  logic                                 sample_stall,
    output logic signed [tctg_pkg::SAMPLE_W-1:0] sample,
    input  logic                                 cfg_we,
    input  logic [tctg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tctg_pkg::CFG_DATA_W-1:0]      cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ANGLE = 8'b0000_0010,
        S_SINE  = 8'b0000_0100,
        S_NORM  = 8'b0000_1000,
        S_SCALE = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_STEP  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    localparam logic [tctg_pkg::ITER_W-1:0] ANGLE_LAST = tctg_pkg::ITER_W'(ANGLE_ITERATIONS - 1);
    localparam logic [tctg_pkg::ITER_W-1:0] SINE_LAST =
        tctg_pkg::ITER_W'(tctg_pkg::SINE_STAGES - 1);

    state_t state_reg, state_next;

    logic [tctg_pkg::MARKER_W-1:0] marker_reg, marker_next;
    logic [tctg_pkg::STEP_W-1:0]   base_reg, base_next;
    logic [tctg_pkg::STEP_W-1:0]   span_reg, span_next;
    logic [tctg_pkg::AMP_W-1:0]    amp_reg, amp_next;

    logic [PHASE_BITS-1:0]         acc_reg, acc_next;
    logic [tctg_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                          active_reg, active_next;
    logic [tctg_pkg::ITER_W-1:0]   iter_reg, iter_next;

    logic [tctg_pkg::MUL_A_W-1:0]  mul_a_reg, mul_a_next;
    logic [tctg_pkg::MUL_B_W-1:0]  mul_b_reg, mul_b_next;
    logic [tctg_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic                          kind_reg, kind_next;
    logic                          sign_reg, sign_next;

    logic                          out_valid_reg, out_valid_next;
    logic signed [tctg_pkg::SAMPLE_W-1:0] sample_reg, sample_next;

    logic                          accept;
    logic                          byte_en;
    logic                          frame_done;
    logic [15:0]                   x_word;
    logic [15:0]                   y_word;

    tctg_pkg::cordic_ctrl_t              cordic_ctrl;
    logic signed [tctg_pkg::XY_W-1:0]    load_x, load_y;
    logic signed [tctg_pkg::Z_W-1:0]     load_z;
    logic signed [tctg_pkg::XY_W-1:0]    cy;
    logic signed [tctg_pkg::Z_W-1:0]     cz;

    logic signed [tctg_pkg::XY_W-1:0]    vx, vy;
    logic [SINE_TABLE_BITS-1:0]          phase_idx;
    logic [tctg_pkg::ANGLE_W-1:0]        angle;
    logic signed [tctg_pkg::Z_W-1:0]     s_raw, s_fold;
    logic signed [tctg_pkg::Z_W-1:0]     n_raw;
    logic [tctg_pkg::NORM_W-1:0]         norm;
    logic signed [tctg_pkg::XY_W-1:0]    y_mag;
    logic [18:0]                         q_mag;
    logic [tctg_pkg::SAMPLE_W-1:0]       q_clamp;
    logic                                slot_free;

    localparam int QHI = 30 + 18;

    assign accept = item_valid && !item_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign byte_en = accept && !func;
    assign slot_free = !out_valid_reg || !sample_stall;

    tctg_frame u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_en    (byte_en),
        .rx_byte    (serial_byte),
        .marker     (marker_reg),
        .frame_done (frame_done),
        .x_word     (x_word),
        .y_word     (y_word)
    );

    tctg_cordic u_cordic (
        .clk    (clk),
        .ctrl   (cordic_ctrl),
        .load_x (load_x),
        .load_y (load_y),
        .load_z (load_z),
        .y_out  (cy),
        .z_out  (cz)
    );

    assign vx = {{(tctg_pkg::XY_W-16){x_word[15]}}, x_word};
    assign vy = {{(tctg_pkg::XY_W-16){y_word[15]}}, y_word};

    assign phase_idx = acc_reg[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign angle = {phase_idx, {(tctg_pkg::ANGLE_W-SINE_TABLE_BITS){1'b0}}};
    assign s_raw = {{(tctg_pkg::Z_W-tctg_pkg::ANGLE_W){angle[tctg_pkg::ANGLE_W-1]}}, angle};

    always_comb
    begin
        priority if (s_raw > tctg_pkg::QUARTER_TURN)
        begin
            s_fold = tctg_pkg::HALF_TURN - s_raw;
        end
        else if (s_raw < -tctg_pkg::QUARTER_TURN)
        begin
            s_fold = -tctg_pkg::HALF_TURN - s_raw;
        end
        else
        begin
            s_fold = s_raw;
        end
    end

    assign n_raw = cz + tctg_pkg::HALF_TURN;

    always_comb
    begin
        priority if (n_raw < 0)
        begin
            norm = '0;
        end
        else if (n_raw > tctg_pkg::FULL_TURN)
        begin
            norm = tctg_pkg::NORM_NEG_AXIS;
        end
        else
        begin
            norm = n_raw[32:16];
        end
    end

    assign y_mag = cy[tctg_pkg::XY_W-1] ? -cy : cy;
    assign q_mag = prod_reg[QHI:30];
    assign q_clamp = (q_mag > 19'd32767) ? 16'd32767 : q_mag[15:0];

    always_comb
    begin
        state_next = state_reg;
        marker_next = marker_reg;
        base_next = base_reg;
        span_next = span_reg;
        amp_next = amp_reg;
        acc_next = acc_reg;
        step_next = step_reg;
        active_next = active_reg;
        iter_next = iter_reg;
        mul_a_next = mul_a_reg;
        mul_b_next = mul_b_reg;
        prod_next = prod_reg;
        kind_next = kind_reg;
        sign_next = sign_reg;
        out_valid_next = out_valid_reg && sample_stall;
        sample_next = sample_reg;
        cordic_ctrl = '0;
        cordic_ctrl.idx = iter_reg;
        load_x = vx;
        load_y = vy;
        load_z = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                tctg_pkg::REG_FRAME_MARKER: marker_next = cfg_data[tctg_pkg::MARKER_W-1:0];
                tctg_pkg::REG_BASE_STEP:    base_next = cfg_data[tctg_pkg::STEP_W-1:0];
                tctg_pkg::REG_SPAN_STEP:    span_next = cfg_data[tctg_pkg::STEP_W-1:0];
                tctg_pkg::REG_AMPLITUDE:    amp_next = cfg_data[tctg_pkg::AMP_W-1:0];
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                iter_next = '0;
                if (accept)
                begin
                    if (!func)
                    begin
                        if (frame_done)
                        begin
                            kind_next = 1'b0;
                            if (y_word == 16'd0)
                            begin
                                mul_a_next = span_reg;
                                mul_b_next = x_word[15] ? tctg_pkg::NORM_NEG_AXIS
                                                        : tctg_pkg::NORM_POS_AXIS;
                                state_next = S_MUL;
                            end
                            else
                            begin
                                cordic_ctrl.load = 1'b1;
                                if (x_word[15])
                                begin
                                    load_x = -vx;
                                    load_y = -vy;
                                    load_z = y_word[15] ? -tctg_pkg::HALF_TURN
                                                        : tctg_pkg::HALF_TURN;
                                end
                                state_next = S_ANGLE;
                            end
                        end
                    end
                    else if (active_reg)
                    begin
                        cordic_ctrl.load = 1'b1;
                        load_x = tctg_pkg::SINE_START;
                        load_y = '0;
                        load_z = s_fold;
                        acc_next = acc_reg + PHASE_BITS'(step_reg);
                        kind_next = 1'b1;
                        state_next = S_SINE;
                    end
                end
            end
            S_ANGLE:
            begin
                cordic_ctrl.iterate = 1'b1;
                cordic_ctrl.vectoring = 1'b1;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ANGLE_LAST)
                begin
                    state_next = S_NORM;
                end
            end
            S_SINE:
            begin
                cordic_ctrl.iterate = 1'b1;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == SINE_LAST)
                begin
                    state_next = S_SCALE;
                end
            end
            S_NORM:
            begin
                mul_a_next = span_reg;
                mul_b_next = norm;
                state_next = S_MUL;
            end
            S_SCALE:
            begin
                mul_a_next = y_mag[tctg_pkg::MUL_A_W-1:0];
                mul_b_next = {{(tctg_pkg::MUL_B_W-tctg_pkg::AMP_W){1'b0}}, amp_reg};
                sign_next = cy[tctg_pkg::XY_W-1];
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next = mul_a_reg * mul_b_reg;
                state_next = kind_reg ? S_OUT : S_STEP;
            end
            S_STEP:
            begin
                step_next = base_reg + prod_reg[47:16];
                active_next = 1'b1;
                state_next = S_IDLE;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    sample_next = sign_reg ? -signed'(q_clamp) : signed'(q_clamp);
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            marker_reg <= tctg_pkg::FRAME_MARKER_RESET;
            base_reg <= tctg_pkg::BASE_STEP_RESET;
            span_reg <= tctg_pkg::SPAN_STEP_RESET;
            amp_reg <= tctg_pkg::AMPLITUDE_RESET;
            acc_reg <= '0;
            step_reg <= '0;
            active_reg <= 1'b0;
            iter_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            marker_reg <= marker_next;
            base_reg <= base_next;
            span_reg <= span_next;
            amp_reg <= amp_next;
            acc_reg <= acc_next;
            step_reg <= step_next;
            active_reg <= active_next;
            iter_reg <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        prod_reg <= prod_next;
        kind_reg <= kind_next;
        sign_reg <= sign_next;
        sample_reg <= sample_next;
    end

    assign sample_valid = out_valid_reg;
    assign sample = sample_reg;

endmodule
